@@ sv/sca_pkg.sv @@
package sca_pkg;

  localparam int DEF_CHANNELS = 8;
  localparam int DEF_NUM_SFX  = 128;

  localparam logic [1:0] FN_START    = 2'd0;
  localparam logic [1:0] FN_STOP     = 2'd1;
  localparam logic [1:0] FN_FINISH   = 2'd2;
  localparam logic [1:0] FN_STOP_ALL = 2'd3;

  localparam logic [2:0] ST_FREE     = 3'd0;
  localparam logic [2:0] ST_SAME     = 3'd1;
  localparam logic [2:0] ST_STOLEN   = 3'd2;
  localparam logic [2:0] ST_NONE     = 3'd3;
  localparam logic [2:0] ST_REJECTED = 3'd4;
  localparam logic [2:0] ST_STOPPED  = 3'd5;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] origin_id;
    logic [7:0]  sound_id;
    logic [2:0]  channel_index;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  granted_channel;
    logic [7:0]  evicted_sound;
    logic [15:0] evicted_origin;
    logic [3:0]  stopped_count;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic issue;
    logic eval;
    logic finish;
  } sca_cmd_t;

  typedef struct packed {
    logic last;
  } sca_sts_t;

endpackage

@@ sv/sca_ctrl.sv @@
module sca_ctrl
  import sca_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  sca_sts_t sts,
  output sca_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_TAIL = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       eval_r;

  always_comb begin
    state_nxt  = state_r;
    cmd.load   = 1'b0;
    cmd.issue  = 1'b0;
    cmd.finish = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.issue = 1'b1;
        if (sts.last) begin
          state_nxt = S_TAIL;
        end
      end
      S_TAIL: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    cmd.eval = eval_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      eval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      eval_r  <= cmd.issue;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

@@ sv/sca_datapath.sv @@
module sca_datapath
  import sca_pkg::*;
#(
  parameter int CHANNELS = DEF_CHANNELS,
  parameter int NUM_SFX  = DEF_NUM_SFX
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  sca_cmd_t  cmd,
  output sca_sts_t  sts,
  output logic      out_valid,
  output out_item_t out_data
);

  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int IW = (CW > 3) ? CW : 3;
  localparam logic [CW-1:0] LAST_IDX = CW'(CHANNELS - 1);
  localparam logic [8:0] SFX_LIMIT = 9'(NUM_SFX);

  in_item_t          item_r;
  logic [CW-1:0]     idx_r;
  logic [7:0]        mem_sound [CHANNELS];
  logic [15:0]       mem_origin [CHANNELS];
  logic [CHANNELS-1:0] valid_r;

  logic [7:0]        rd_sound_r;
  logic [15:0]       rd_origin_r;
  logic              rd_valid_r;
  logic [CW-1:0]     rd_idx_r;

  logic              same_hit_r;
  logic [CW-1:0]     same_i_r;
  logic              free_hit_r;
  logic [CW-1:0]     free_i_r;
  logic [7:0]        max_s_r;
  logic [15:0]       max_o_r;
  logic [CW-1:0]     max_i_r;
  logic [3:0]        cnt_r;

  logic              out_valid_r;
  out_item_t         out_data_r;

  logic              origin_hit;
  logic              same_now;
  logic              kill;
  logic              sid_bad;
  logic              commit;
  logic [CW-1:0]     grant;
  logic [IW-1:0]     grant_ext;
  out_item_t         res;

  // per-channel checks on the beat read last cycle
  always_comb begin
    origin_hit = rd_valid_r && (item_r.origin_id != 16'd0) &&
                 (rd_origin_r == item_r.origin_id);
    same_now   = origin_hit && (rd_sound_r == item_r.sound_id);
    case (item_r.func)
      FN_STOP:     kill = origin_hit;
      FN_FINISH:   kill = rd_valid_r &&
                          (IW'(rd_idx_r) == IW'(item_r.channel_index));
      FN_STOP_ALL: kill = rd_valid_r;
      default:     kill = 1'b0;
    endcase
  end

  // final decision
  always_comb begin
    sid_bad = (item_r.sound_id == 8'd0) || ({1'b0, item_r.sound_id} >= SFX_LIMIT);
    commit  = 1'b0;
    grant   = '0;
    res     = '0;
    if (item_r.func == FN_START) begin
      if (sid_bad) begin
        res.status = ST_REJECTED;
      end else if (same_hit_r) begin
        res.status         = ST_SAME;
        grant              = same_i_r;
        commit             = 1'b1;
        res.evicted_sound  = item_r.sound_id;
        res.evicted_origin = item_r.origin_id;
      end else if (free_hit_r) begin
        res.status = ST_FREE;
        grant      = free_i_r;
        commit     = 1'b1;
      end else if (item_r.sound_id <= max_s_r) begin
        res.status         = ST_STOLEN;
        grant              = max_i_r;
        commit             = 1'b1;
        res.evicted_sound  = max_s_r;
        res.evicted_origin = max_o_r;
      end else begin
        res.status = ST_NONE;
      end
    end else begin
      res.status        = ST_STOPPED;
      res.stopped_count = cnt_r;
    end
    grant_ext           = IW'(grant);
    res.granted_channel = grant_ext[2:0];
  end

  assign sts.last = (idx_r == LAST_IDX);

  // channel table and scan read port
  always_ff @(posedge clk) begin
    if (cmd.finish && commit) begin
      mem_sound[grant]  <= item_r.sound_id;
      mem_origin[grant] <= item_r.origin_id;
    end
    if (cmd.issue) begin
      rd_sound_r  <= mem_sound[idx_r];
      rd_origin_r <= mem_origin[idx_r];
      rd_valid_r  <= valid_r[idx_r];
      rd_idx_r    <= idx_r;
    end
  end

  // busy flags per channel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (cmd.eval && kill) begin
        valid_r[rd_idx_r] <= 1'b0;
      end
      if (cmd.finish && commit) begin
        valid_r[grant] <= 1'b1;
      end
    end
  end

  // scan trackers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r     <= in_data;
      idx_r      <= '0;
      same_hit_r <= 1'b0;
      same_i_r   <= '0;
      free_hit_r <= 1'b0;
      free_i_r   <= '0;
      max_s_r    <= 8'd0;
      max_o_r    <= 16'd0;
      max_i_r    <= '0;
      cnt_r      <= 4'd0;
    end else begin
      if (cmd.issue) begin
        idx_r <= idx_r + 1'b1;
      end
      if (cmd.eval) begin
        if (kill && (cnt_r != 4'hF)) begin
          cnt_r <= cnt_r + 4'd1;
        end
        if ((item_r.func == FN_START) && !same_hit_r) begin
          if (same_now) begin
            same_hit_r <= 1'b1;
            same_i_r   <= rd_idx_r;
          end else if (!rd_valid_r) begin
            if (!free_hit_r) begin
              free_hit_r <= 1'b1;
              free_i_r   <= rd_idx_r;
            end
          end else if (rd_sound_r > max_s_r) begin
            max_s_r <= rd_sound_r;
            max_o_r <= rd_origin_r;
            max_i_r <= rd_idx_r;
          end
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ sv/sound_channel_allocator_core.sv @@
// Voice channel allocator. A request is taken when start is high and busy is low; its
// result appears on out_data for exactly one cycle with out_valid high, and there is no
// way to hold it off, so the receiver must capture it in that cycle. Every request walks
// the channel table one entry per cycle through its single read port, and the
// next request can be taken in the cycle its predecessor's result is shown. The table is
// free right after reset, no clearing pass is needed.
module sound_channel_allocator_core
  import sca_pkg::*;
#(
  parameter int CHANNELS = DEF_CHANNELS,
  parameter int NUM_SFX  = DEF_NUM_SFX
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  output logic      out_valid,
  output out_item_t out_data
);

  sca_cmd_t cmd;
  sca_sts_t sts;

  sca_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  sca_datapath #(
    .CHANNELS (CHANNELS),
    .NUM_SFX  (NUM_SFX)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
